// ===== rtl/core/awb_pkg.sv =====
// ----------------------------------------------------------------------------
// awb_pkg
// shared constants, types and helpers of the affine warp bilinear unit
// ----------------------------------------------------------------------------
package awb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int CHANNELS   = 3;
	localparam int FRAC_BITS  = 16;

	localparam int COORD_W = 12;
	localparam int PIX_W   = 8;
	localparam int COEF_W  = 32;
	localparam int SIZE_W  = 9;

	localparam int X_BITS     = $clog2(MAX_WIDTH);
	localparam int Y_BITS     = $clog2(MAX_HEIGHT);
	localparam int NBANKS     = 4;
	localparam int BANK_AW    = (X_BITS - 1) + (Y_BITS - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int WORD_W     = CHANNELS * PIX_W;

	localparam int PROD_W  = COEF_W + COORD_W + 1;
	localparam int SUM_W   = PROD_W + 2;
	localparam int IDX_W   = SUM_W - FRAC_BITS;
	localparam int IDX1_W  = IDX_W + 1;
	localparam int FRAC1_W = FRAC_BITS + 1;
	localparam int WMUL_W  = 2 * FRAC1_W;
	localparam int WGT_W   = 2 * FRAC_BITS + 1;
	localparam int MAC_W   = WGT_W + PIX_W;
	localparam int ACC_W   = MAC_W + 2;
	localparam int BLEND_W = ACC_W - 2 * FRAC_BITS;

	localparam logic [FRAC1_W-1:0] ONE_FRAC = FRAC1_W'(1) << FRAC_BITS;
	localparam logic [PIX_W-1:0]   PIX_MAX  = '1;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_WARP = 1'b1;

	// register indexes
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_XX    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEF_XY    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_YX    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_YY    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd7;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_xx;
		logic signed [COEF_W-1:0] coef_xy;
		logic signed [COEF_W-1:0] offset_x;
		logic signed [COEF_W-1:0] coef_yx;
		logic signed [COEF_W-1:0] coef_yy;
		logic signed [COEF_W-1:0] offset_y;
		logic [SIZE_W-1:0]        src_width;
		logic [SIZE_W-1:0]        src_height;
	} cfg_t;

	// mapped item leaving the coordinate pipeline; loads use x0/y0 as the store position
	typedef struct packed {
		logic                 vld;
		logic                 warp;
		logic                 ld_ok;
		logic [X_BITS-1:0]    x0;
		logic [X_BITS-1:0]    x1;
		logic [Y_BITS-1:0]    y0;
		logic [Y_BITS-1:0]    y1;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic [WORD_W-1:0]    pix;
	} map_t;

	function automatic logic [X_BITS-1:0] lim_x(input logic [SIZE_W-1:0] s);
		logic [X_BITS-1:0] r;
		if (s == '0)
			r = '0;
		else if (s > SIZE_W'(MAX_WIDTH))
			r = X_BITS'(MAX_WIDTH - 1);
		else
			r = X_BITS'(s - SIZE_W'(1));
		return r;
	endfunction

	function automatic logic [Y_BITS-1:0] lim_y(input logic [SIZE_W-1:0] s);
		logic [Y_BITS-1:0] r;
		if (s == '0)
			r = '0;
		else if (s > SIZE_W'(MAX_HEIGHT))
			r = Y_BITS'(MAX_HEIGHT - 1);
		else
			r = Y_BITS'(s - SIZE_W'(1));
		return r;
	endfunction

	function automatic logic [X_BITS-1:0] clamp_x(input logic signed [IDX1_W-1:0] v,
		input logic [X_BITS-1:0] lim);
		logic [X_BITS-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({{(IDX1_W - X_BITS){1'b0}}, lim}))
			r = lim;
		else
			r = v[X_BITS-1:0];
		return r;
	endfunction

	function automatic logic [Y_BITS-1:0] clamp_y(input logic signed [IDX1_W-1:0] v,
		input logic [Y_BITS-1:0] lim);
		logic [Y_BITS-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({{(IDX1_W - Y_BITS){1'b0}}, lim}))
			r = lim;
		else
			r = v[Y_BITS-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/awb_ram.sv =====
// ----------------------------------------------------------------------------
// awb_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module awb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/awb_map.sv =====
// ----------------------------------------------------------------------------
// awb_map
// three stage coordinate pipeline: affine products, sums, floor and clamping
// ----------------------------------------------------------------------------
module awb_map (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic                         command,
	input  logic [awb_pkg::COORD_W-1:0]  coord_x,
	input  logic [awb_pkg::COORD_W-1:0]  coord_y,
	input  logic [awb_pkg::WORD_W-1:0]   pix,
	input  awb_pkg::cfg_t                cfg,
	output awb_pkg::map_t                m_s3
);

	import awb_pkg::*;

	logic                       vld_s1, vld_s2, vld_s3;
	logic                       warp_s1, warp_s2, warp_s3;
	logic                       ld_ok_s1, ld_ok_s2, ld_ok_s3;
	logic [COORD_W-1:0]         x_s1, y_s1, x_s2, y_s2;
	logic [WORD_W-1:0]          pix_s1, pix_s2, pix_s3;
	logic signed [PROD_W-1:0]   pxx_s1, pxy_s1, pyx_s1, pyy_s1;
	logic signed [SUM_W-1:0]    sx_s2, sy_s2;
	logic signed [IDX1_W-1:0]   ix, iy, ix1, iy1;
	logic [X_BITS-1:0]          xlim;
	logic [Y_BITS-1:0]          ylim;
	logic signed [PROD_W-1:0]   xs, ys;
	logic [X_BITS-1:0]          x0_s3, x1_s3;
	logic [Y_BITS-1:0]          y0_s3, y1_s3;
	logic [FRAC_BITS-1:0]       fx_s3, fy_s3;

	assign xs = PROD_W'($signed({1'b0, coord_x}));
	assign ys = PROD_W'($signed({1'b0, coord_y}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		warp_s1  <= (command == CMD_WARP);
		ld_ok_s1 <= (coord_x < COORD_W'(MAX_WIDTH)) && (coord_y < COORD_W'(MAX_HEIGHT));
		x_s1     <= coord_x;
		y_s1     <= coord_y;
		pix_s1   <= pix;
		pxx_s1   <= PROD_W'(cfg.coef_xx) * xs;
		pxy_s1   <= PROD_W'(cfg.coef_xy) * ys;
		pyx_s1   <= PROD_W'(cfg.coef_yx) * xs;
		pyy_s1   <= PROD_W'(cfg.coef_yy) * ys;
	end

	// stage 2: sums
	always_ff @(posedge clk) begin
		warp_s2  <= warp_s1;
		ld_ok_s2 <= ld_ok_s1;
		x_s2     <= x_s1;
		y_s2     <= y_s1;
		pix_s2   <= pix_s1;
		sx_s2    <= SUM_W'(pxx_s1) + SUM_W'(pxy_s1) + SUM_W'(cfg.offset_x);
		sy_s2    <= SUM_W'(pyx_s1) + SUM_W'(pyy_s1) + SUM_W'(cfg.offset_y);
	end

	// stage 3: floor, neighbors and edge clamp
	always_comb begin
		ix   = IDX1_W'($signed(sx_s2[SUM_W-1:FRAC_BITS]));
		iy   = IDX1_W'($signed(sy_s2[SUM_W-1:FRAC_BITS]));
		ix1  = ix + IDX1_W'(1);
		iy1  = iy + IDX1_W'(1);
		xlim = lim_x(cfg.src_width);
		ylim = lim_y(cfg.src_height);
	end

	always_ff @(posedge clk) begin
		warp_s3  <= warp_s2;
		ld_ok_s3 <= ld_ok_s2;
		pix_s3   <= pix_s2;
		fx_s3    <= sx_s2[FRAC_BITS-1:0];
		fy_s3    <= sy_s2[FRAC_BITS-1:0];
		x1_s3    <= clamp_x(ix1, xlim);
		y1_s3    <= clamp_y(iy1, ylim);
		if (warp_s2) begin
			x0_s3 <= clamp_x(ix, xlim);
			y0_s3 <= clamp_y(iy, ylim);
		end else begin
			x0_s3 <= x_s2[X_BITS-1:0];
			y0_s3 <= y_s2[Y_BITS-1:0];
		end
	end

	assign m_s3 = '{vld: vld_s3, warp: warp_s3, ld_ok: ld_ok_s3, x0: x0_s3, x1: x1_s3,
		y0: y0_s3, y1: y1_s3, fx: fx_s3, fy: fy_s3, pix: pix_s3};

endmodule

// ===== rtl/core/awb_lane.sv =====
// ----------------------------------------------------------------------------
// awb_lane
// one color channel: four weighted neighbor products and their sum
// ----------------------------------------------------------------------------
module awb_lane (
	input  logic                          clk,
	input  logic [awb_pkg::PIX_W-1:0]     pix [awb_pkg::NBANKS],
	input  logic [awb_pkg::WGT_W-1:0]     wgt [awb_pkg::NBANKS],
	output logic [awb_pkg::BLEND_W-1:0]   blend
);

	import awb_pkg::*;

	logic [MAC_W-1:0] prod_s5 [NBANKS];
	logic [ACC_W-1:0] acc;

	always_ff @(posedge clk) begin
		for (int k = 0; k < NBANKS; k++)
			prod_s5[k] <= MAC_W'(pix[k]) * MAC_W'(wgt[k]);
	end

	always_comb begin
		acc = '0;
		for (int k = 0; k < NBANKS; k++)
			acc = acc + ACC_W'(prod_s5[k]);
		blend = acc[ACC_W-1:2*FRAC_BITS];
	end

endmodule

// ===== rtl/core/affine_warp_bilinear_bgr_unit.sv =====
// ----------------------------------------------------------------------------
// affine_warp_bilinear_bgr_unit
// inverse affine warp with bilinear blend over a banked bgr source store
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  command   start, busy, command, coord_x/y, in_*   start & !busy
//  result    done, out_blue/green/red                done, one cycle
//  config    wr_en, wr_index, wr_data                wr_en
//
//  one word per cycle; a warp result shows on done once it has passed stages s1 to s6
//  busy stays low: the pipeline takes a word every cycle
//  loads write the store in the same stage where warps read, so order holds
//  the store is four parity banks so all four neighbors read in the same cycle
//  reset clears control and loads the register defaults; the store is not cleared
// ----------------------------------------------------------------------------
module affine_warp_bilinear_bgr_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [awb_pkg::COORD_W-1:0]       coord_x,
	input  logic [awb_pkg::COORD_W-1:0]       coord_y,
	input  logic [awb_pkg::PIX_W-1:0]         in_blue,
	input  logic [awb_pkg::PIX_W-1:0]         in_green,
	input  logic [awb_pkg::PIX_W-1:0]         in_red,
	input  logic                              wr_en,
	input  logic [awb_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [awb_pkg::COEF_W-1:0]        wr_data,
	output logic                              done,
	output logic [awb_pkg::PIX_W-1:0]         out_blue,
	output logic [awb_pkg::PIX_W-1:0]         out_green,
	output logic [awb_pkg::PIX_W-1:0]         out_red
);

	import awb_pkg::*;

	cfg_t               cfg_q;
	map_t               m_s3;
	logic               take;
	logic [WORD_W-1:0]  pix_in;

	logic [BANK_AW-1:0] raddr [NBANKS];
	logic [BANK_AW-1:0] waddr;
	logic [WORD_W-1:0]  rdata [NBANKS];
	logic               bank_we [NBANKS];

	logic [FRAC1_W-1:0] gx, gy, fxe, fye;
	logic               vld_s4, vld_s5, vld_s6;
	logic               x0p_s4, x1p_s4, y0p_s4, y1p_s4;
	logic [WGT_W-1:0]   wgt_s4 [NBANKS];
	logic [WORD_W-1:0]  nbr [NBANKS];
	logic [PIX_W-1:0]   lane_pix [CHANNELS][NBANKS];
	logic [BLEND_W-1:0] blend [CHANNELS];
	logic [PIX_W-1:0]   chan_s6 [CHANNELS];

	assign busy   = 1'b0;
	assign take   = start & ~busy;
	assign pix_in = {in_red, in_green, in_blue};

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx    <= COEF_W'(65536);
			cfg_q.coef_xy    <= '0;
			cfg_q.offset_x   <= '0;
			cfg_q.coef_yx    <= '0;
			cfg_q.coef_yy    <= COEF_W'(65536);
			cfg_q.offset_y   <= '0;
			cfg_q.src_width  <= SIZE_W'(256);
			cfg_q.src_height <= SIZE_W'(256);
		end else if (wr_en) begin
			case (wr_index)
				REG_COEF_XX:    cfg_q.coef_xx    <= wr_data;
				REG_COEF_XY:    cfg_q.coef_xy    <= wr_data;
				REG_OFFSET_X:   cfg_q.offset_x   <= wr_data;
				REG_COEF_YX:    cfg_q.coef_yx    <= wr_data;
				REG_COEF_YY:    cfg_q.coef_yy    <= wr_data;
				REG_OFFSET_Y:   cfg_q.offset_y   <= wr_data;
				REG_SRC_WIDTH:  cfg_q.src_width  <= wr_data[SIZE_W-1:0];
				REG_SRC_HEIGHT: cfg_q.src_height <= wr_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	awb_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.command (command),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.pix     (pix_in),
		.cfg     (cfg_q),
		.m_s3    (m_s3)
	);

	// parity banked store
	assign waddr = {m_s3.y0[Y_BITS-1:1], m_s3.x0[X_BITS-1:1]};

	for (genvar b = 0; b < NBANKS; b++) begin : g_bank
		localparam logic BX = 1'(b % 2);
		localparam logic BY = 1'(b / 2);
		logic [X_BITS-1:0] xsel;
		logic [Y_BITS-1:0] ysel;

		assign xsel       = (m_s3.x0[0] == BX) ? m_s3.x0 : m_s3.x1;
		assign ysel       = (m_s3.y0[0] == BY) ? m_s3.y0 : m_s3.y1;
		assign raddr[b]   = {ysel[Y_BITS-1:1], xsel[X_BITS-1:1]};
		assign bank_we[b] = m_s3.vld & ~m_s3.warp & m_s3.ld_ok
			& (m_s3.x0[0] == BX) & (m_s3.y0[0] == BY);

		awb_ram #(
			.WIDTH (WORD_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (waddr),
			.wdata (m_s3.pix),
			.raddr (raddr[b]),
			.rdata (rdata[b])
		);
	end

	// weights
	always_comb begin
		fxe = FRAC1_W'(m_s3.fx);
		fye = FRAC1_W'(m_s3.fy);
		gx  = ONE_FRAC - fxe;
		gy  = ONE_FRAC - fye;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= m_s3.vld & m_s3.warp;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		x0p_s4    <= m_s3.x0[0];
		x1p_s4    <= m_s3.x1[0];
		y0p_s4    <= m_s3.y0[0];
		y1p_s4    <= m_s3.y1[0];
		wgt_s4[0] <= WGT_W'(WMUL_W'(gx) * WMUL_W'(gy));
		wgt_s4[1] <= WGT_W'(WMUL_W'(fxe) * WMUL_W'(gy));
		wgt_s4[2] <= WGT_W'(WMUL_W'(gx) * WMUL_W'(fye));
		wgt_s4[3] <= WGT_W'(WMUL_W'(fxe) * WMUL_W'(fye));
	end

	// neighbor pick: top left, top right, bottom left, bottom right
	always_comb begin
		nbr[0] = rdata[{y0p_s4, x0p_s4}];
		nbr[1] = rdata[{y0p_s4, x1p_s4}];
		nbr[2] = rdata[{y1p_s4, x0p_s4}];
		nbr[3] = rdata[{y1p_s4, x1p_s4}];
		for (int c = 0; c < CHANNELS; c++)
			for (int k = 0; k < NBANKS; k++)
				lane_pix[c][k] = nbr[k][c*PIX_W +: PIX_W];
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		awb_lane u_lane (
			.clk   (clk),
			.pix   (lane_pix[c]),
			.wgt   (wgt_s4),
			.blend (blend[c])
		);
	end

	// merge: saturate and pack
	always_ff @(posedge clk) begin
		for (int c = 0; c < CHANNELS; c++)
			chan_s6[c] <= (blend[c] > BLEND_W'(PIX_MAX)) ? PIX_MAX : blend[c][PIX_W-1:0];
	end

	assign done      = vld_s6;
	assign out_blue  = chan_s6[0];
	assign out_green = chan_s6[1];
	assign out_red   = chan_s6[2];

endmodule
